>>> hdl/spr_pkg.sv
// Shared types and constants for the sequenced packet reassembler.
// Used by the top level, the port checker and the testbench.
// No dependencies.
package spr_pkg;

    // Default width of the announced transfer length
    localparam int LENGTH_BITS_DEF = 16;

    // Request kinds on the input tuser field
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_EMPTY = 2'd2;

    // Transfer status codes
    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_INTER   = 2'd1;
    localparam logic [1:0] ST_SUCCESS = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Error cause codes
    localparam logic [2:0] CAUSE_NONE       = 3'd0;
    localparam logic [2:0] CAUSE_EMPTY      = 3'd1;
    localparam logic [2:0] CAUSE_SHORT      = 3'd2;
    localparam logic [2:0] CAUSE_UNEXPECTED = 3'd3;
    localparam logic [2:0] CAUSE_SEQUENCE   = 3'd4;

    // Field widths of one result
    localparam int STATUS_W = 2;
    localparam int SEQ_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int LEN_W    = 16;
    localparam int CAUSE_W  = 3;

    // Result tdata layout, lowest bit first, padded to whole bytes
    localparam int RES_BITS = STATUS_W + SEQ_W + BYTE_W + OFFSET_W + LEN_W + CAUSE_W;
    localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - RES_BITS;

endpackage

>>> hdl/sequenced_packet_reassembler.sv
// Sequenced packet reassembler: top level with the per-byte packet decoder.
// Depends on spr_pkg and spr_skid_buf.
//
// Usage:
//   Input channel s_axis_*: one request per transfer. tuser selects clear,
//   packet byte or empty-packet notice; tdata is the packet byte and tlast
//   marks the final byte of a packet. The first byte of a packet is its
//   sequence number; a start packet (sequence 0) carries a little-endian
//   16-bit length before its payload.
//   Output channel m_axis_*: exactly one result per request, in order. It
//   carries status, expected sequence, the accepted payload byte with its
//   offset, the transfer length and the latest error cause.
//   Each result is registered in the output register, or the skid entry on
//   a stall. Throughput: one request per cycle while s_axis_tready is high;
//   the decode for a byte sits between state registers and result buffer.
//   Stall: a two-entry result buffer holds results while m_axis_tready is
//   low; s_axis_tready drops only once both entries are full.
//   Reset: rst_n clears the status, sequence, length, count and cause, and
//   empties the result buffer. A clear request does the same to the state.
module sequenced_packet_reassembler #(
    parameter int LENGTH_BITS = spr_pkg::LENGTH_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // data_byte[7:0]
    input  logic [1:0]                 s_axis_tuser,  // req_type[1:0]
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], expected_seq[9:2], payload_out[17:10],
    // payload_offset[33:18], transfer_length[49:34], error_cause[52:50]
    output logic [spr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                 m_axis_tuser   // payload_valid[0]
);

    typedef enum logic [2:0] {
        PH_SEQ,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    localparam int BUF_W = spr_pkg::TDATA_W + 1;

    logic [1:0]             status_reg, status_next;
    logic [7:0]             seq_reg, seq_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             len_lo_reg, len_lo_next;
    logic [2:0]             cause_reg, cause_next;

    logic                   in_fire;
    logic                   eop;
    logic [15:0]            len_word;
    logic                   pvalid;
    logic [7:0]             pout;
    logic [15:0]            poff;
    logic [BUF_W-1:0]       res_word;
    logic [BUF_W-1:0]       buf_out;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign len_word = {s_axis_tdata, len_lo_reg};

    // Decode one request against the packet state
    always_comb
    begin
        status_next = status_reg;
        seq_next    = seq_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        cause_next  = cause_reg;
        eop         = 1'b0;
        pvalid      = 1'b0;
        pout        = '0;
        poff        = '0;

        if (in_fire)
        begin
            unique case (s_axis_tuser)
                spr_pkg::REQ_CLEAR:
                begin
                    status_next = spr_pkg::ST_CLEAR;
                    seq_next    = '0;
                    total_next  = '0;
                    count_next  = '0;
                    phase_next  = PH_SEQ;
                    len_lo_next = '0;
                    cause_next  = spr_pkg::CAUSE_NONE;
                end
                spr_pkg::REQ_EMPTY:
                begin
                    // Abandon any packet in flight
                    phase_next  = PH_SEQ;
                    status_next = spr_pkg::ST_ERROR;
                    cause_next  = spr_pkg::CAUSE_EMPTY;
                end
                spr_pkg::REQ_BYTE:
                begin
                    unique case (phase_reg)
                        PH_SEQ:
                        begin
                            if (s_axis_tdata == 8'd0)
                            begin
                                if (seq_reg != 8'd0)
                                begin
                                    status_next = spr_pkg::ST_ERROR;
                                    cause_next  = spr_pkg::CAUSE_UNEXPECTED;
                                    phase_next  = s_axis_tlast ? PH_SEQ : PH_DISCARD;
                                end
                                else if (s_axis_tlast)
                                begin
                                    status_next = spr_pkg::ST_ERROR;
                                    cause_next  = spr_pkg::CAUSE_SHORT;
                                end
                                else
                                begin
                                    phase_next = PH_LEN_LO;
                                end
                            end
                            else if (s_axis_tdata != seq_reg)
                            begin
                                status_next = spr_pkg::ST_ERROR;
                                cause_next  = spr_pkg::CAUSE_SEQUENCE;
                                phase_next  = s_axis_tlast ? PH_SEQ : PH_DISCARD;
                            end
                            else if (s_axis_tlast)
                            begin
                                eop = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_LEN_LO:
                        begin
                            if (s_axis_tlast)
                            begin
                                status_next = spr_pkg::ST_ERROR;
                                cause_next  = spr_pkg::CAUSE_SHORT;
                                phase_next  = PH_SEQ;
                            end
                            else
                            begin
                                len_lo_next = s_axis_tdata;
                                phase_next  = PH_LEN_HI;
                            end
                        end
                        PH_LEN_HI:
                        begin
                            // Commit the start packet
                            total_next  = len_word[LENGTH_BITS-1:0];
                            count_next  = '0;
                            seq_next    = '0;
                            status_next = spr_pkg::ST_INTER;
                            eop         = s_axis_tlast;
                            phase_next  = s_axis_tlast ? PH_SEQ : PH_PAYLOAD;
                        end
                        PH_PAYLOAD:
                        begin
                            if (count_reg < total_reg)
                            begin
                                pvalid     = 1'b1;
                                pout       = s_axis_tdata;
                                poff       = 16'(count_reg);
                                count_next = count_reg + LENGTH_BITS'(1);
                            end
                            eop        = s_axis_tlast;
                            phase_next = s_axis_tlast ? PH_SEQ : PH_PAYLOAD;
                        end
                        default:
                        begin
                            // Drop the rest of a rejected packet
                            if (s_axis_tlast)
                            begin
                                phase_next = PH_SEQ;
                            end
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        // Close the packet: finish the transfer or step the sequence
        if (eop)
        begin
            if (count_next >= total_next)
            begin
                status_next = spr_pkg::ST_SUCCESS;
            end
            else
            begin
                seq_next = seq_next + 8'd1;
            end
        end
    end

    // Hold the packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= spr_pkg::ST_CLEAR;
            seq_reg    <= '0;
            total_reg  <= '0;
            count_reg  <= '0;
            phase_reg  <= PH_SEQ;
            len_lo_reg <= '0;
            cause_reg  <= spr_pkg::CAUSE_NONE;
        end
        else
        begin
            status_reg <= status_next;
            seq_reg    <= seq_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            cause_reg  <= cause_next;
        end
    end

    // Pack the result: payload_valid on top, tdata fields below
    assign res_word = {pvalid,
                       {spr_pkg::PAD_W{1'b0}},
                       cause_next,
                       16'(total_next),
                       poff,
                       pout,
                       seq_next,
                       status_next};

    spr_skid_buf #(
        .DATA_W (BUF_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (res_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (buf_out)
    );

    assign m_axis_tdata = buf_out[spr_pkg::TDATA_W-1:0];
    assign m_axis_tuser = buf_out[BUF_W-1 -: 1];

endmodule

>>> hdl/spr_skid_buf.sv
// Two-entry output buffer for the reassembler result stream.
// The input side ready comes from a register, so a stall on the output
// does not reach the input combinationally. Depends on nothing.
module spr_skid_buf #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              in_fire;
    logic              out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = out_ready || !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Advance the skid entry into the output, or park a request that meets a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload path, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

>>> hdl/spr_checker.sv
// Port-level checks for the sequenced packet reassembler, bound to the top.
// Depends on spr_pkg and sequenced_packet_reassembler.
module spr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [7:0]                  s_axis_tdata,
    input logic [1:0]                  s_axis_tuser,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [spr_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                  m_axis_tuser
);

    // Input back-pressure only once a result is already waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Accepted payload lies inside the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[33:18] < m_axis_tdata[49:34])
        else $error("payload offset beyond transfer length");

    // Error status always carries a cause
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == spr_pkg::ST_ERROR
            |-> m_axis_tdata[52:50] != spr_pkg::CAUSE_NONE)
        else $error("error status without cause");

endmodule

bind sequenced_packet_reassembler spr_checker u_spr_checker (.*);

>>> dv/sequenced_packet_reassembler_tb.sv
// Self-checking testbench for the sequenced packet reassembler: a queued request driver,
// a result monitor and a request-level predictor of the per-byte decoder.
// Depends on spr_pkg and the sequenced_packet_reassembler top level.
module sequenced_packet_reassembler_tb;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [15:0] LEN_MASK     = 16'((1 << spr_pkg::LENGTH_BITS_DEF) - 1);
    localparam int          RANDOM_REQS  = 1000;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 200;

    typedef enum logic [2:0] {
        AWAIT_SEQ,
        AWAIT_LEN_LO,
        AWAIT_LEN_HI,
        IN_PAYLOAD,
        DISCARDING
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] octet;
        logic       eop;
    } link_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  seq;
        logic        valid;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [15:0] length;
        logic [2:0]  cause;
    } progress_t;

    // Result tdata as laid out on the port, highest field first
    typedef struct packed {
        logic [spr_pkg::PAD_W-1:0]    pad;
        logic [spr_pkg::CAUSE_W-1:0]  cause;
        logic [spr_pkg::LEN_W-1:0]    length;
        logic [spr_pkg::OFFSET_W-1:0] offset;
        logic [spr_pkg::BYTE_W-1:0]   data;
        logic [spr_pkg::SEQ_W-1:0]    seq;
        logic [spr_pkg::STATUS_W-1:0] status;
    } report_bits_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = 8'h00;
    logic [1:0]                  s_axis_tuser = spr_pkg::REQ_CLEAR;
    logic                        s_axis_tlast = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [spr_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                  m_axis_tuser;

    // Predictor state
    logic [1:0]   xfer_status = spr_pkg::ST_CLEAR;
    logic [7:0]   next_seq    = 8'h00;
    logic [15:0]  xfer_len    = 16'h0000;
    logic [15:0]  bytes_taken = 16'h0000;
    parse_state_t parse_at    = AWAIT_SEQ;
    logic [7:0]   len_low     = 8'h00;
    logic [2:0]   last_cause  = spr_pkg::CAUSE_NONE;

    link_req_t link_reqs_pending[$];
    progress_t progress_due[$];

    int  stim_items    = 0;
    int  total_reqs    = 0;
    int  reqs_taken    = 0;
    int  reports_seen  = 0;
    int  mismatches    = 0;
    int  payload_seen  = 0;
    int  success_seen  = 0;
    int  error_seen    = 0;
    int  stall_cycles  = 0;
    logic in_fire      = 1'b0;

    // Generator view of the link
    logic [7:0] gen_seq  = 8'h00;
    int         gen_left = 0;

    sequenced_packet_reassembler #(
        .LENGTH_BITS(spr_pkg::LENGTH_BITS_DEF)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void flag_error(input logic [2:0] cause);
        xfer_status = spr_pkg::ST_ERROR;
        last_cause  = cause;
    endfunction

    // Finish the transfer or step the expected sequence
    function automatic void close_packet();
        if (bytes_taken >= xfer_len)
            xfer_status = spr_pkg::ST_SUCCESS;
        else
            next_seq = next_seq + 8'd1;
    endfunction

    // Advance the decoder by one request and return the progress report it yields
    function automatic progress_t advance_reassembly(input logic [1:0] kind,
                                                     input logic [7:0] octet,
                                                     input logic eop);
        progress_t r;
        r.valid  = 1'b0;
        r.data   = 8'h00;
        r.offset = 16'h0000;
        case (kind)
            spr_pkg::REQ_CLEAR:
            begin
                xfer_status = spr_pkg::ST_CLEAR;
                next_seq    = 8'h00;
                xfer_len    = 16'h0000;
                bytes_taken = 16'h0000;
                parse_at    = AWAIT_SEQ;
                len_low     = 8'h00;
                last_cause  = spr_pkg::CAUSE_NONE;
            end
            spr_pkg::REQ_EMPTY:
            begin
                parse_at = AWAIT_SEQ;
                flag_error(spr_pkg::CAUSE_EMPTY);
            end
            spr_pkg::REQ_BYTE:
            begin
                case (parse_at)
                    AWAIT_SEQ:
                    begin
                        if (octet == 8'h00)
                        begin
                            if (next_seq != 8'h00)
                            begin
                                flag_error(spr_pkg::CAUSE_UNEXPECTED);
                                parse_at = eop ? AWAIT_SEQ : DISCARDING;
                            end
                            else if (eop)
                                flag_error(spr_pkg::CAUSE_SHORT);
                            else
                                parse_at = AWAIT_LEN_LO;
                        end
                        else if (octet != next_seq)
                        begin
                            flag_error(spr_pkg::CAUSE_SEQUENCE);
                            parse_at = eop ? AWAIT_SEQ : DISCARDING;
                        end
                        else if (eop)
                            close_packet();
                        else
                            parse_at = IN_PAYLOAD;
                    end
                    AWAIT_LEN_LO:
                    begin
                        if (eop)
                        begin
                            flag_error(spr_pkg::CAUSE_SHORT);
                            parse_at = AWAIT_SEQ;
                        end
                        else
                        begin
                            len_low  = octet;
                            parse_at = AWAIT_LEN_HI;
                        end
                    end
                    AWAIT_LEN_HI:
                    begin
                        // Commit the start packet
                        xfer_len    = {octet, len_low} & LEN_MASK;
                        bytes_taken = 16'h0000;
                        next_seq    = 8'h00;
                        xfer_status = spr_pkg::ST_INTER;
                        if (eop)
                        begin
                            close_packet();
                            parse_at = AWAIT_SEQ;
                        end
                        else
                            parse_at = IN_PAYLOAD;
                    end
                    IN_PAYLOAD:
                    begin
                        // Drop bytes beyond the announced length
                        if (bytes_taken < xfer_len)
                        begin
                            r.valid     = 1'b1;
                            r.data      = octet;
                            r.offset    = bytes_taken;
                            bytes_taken = (bytes_taken + 16'd1) & LEN_MASK;
                        end
                        if (eop)
                        begin
                            close_packet();
                            parse_at = AWAIT_SEQ;
                        end
                    end
                    default:
                    begin
                        if (eop)
                            parse_at = AWAIT_SEQ;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        r.status = xfer_status;
        r.seq    = next_seq;
        r.length = xfer_len;
        r.cause  = last_cause;
        return r;
    endfunction

    task automatic push_req(input logic [1:0] kind, input logic [7:0] octet, input logic eop);
        link_req_t item;
        item.kind  = kind;
        item.octet = octet;
        item.eop   = eop;
        link_reqs_pending.push_back(item);
        if (kind != REQ_UNUSED)
            stim_items++;
    endtask

    task automatic push_payload(input int n_payload);
        for (int i = 0; i < n_payload; i++)
            push_req(spr_pkg::REQ_BYTE, 8'($urandom), i == n_payload - 1);
    endtask

    task automatic push_packet(input logic [7:0] seq, input int n_payload);
        push_req(spr_pkg::REQ_BYTE, seq, n_payload == 0);
        push_payload(n_payload);
    endtask

    task automatic push_start(input logic [15:0] len, input int n_payload);
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, len[7:0], 1'b0);
        push_req(spr_pkg::REQ_BYTE, len[15:8], n_payload == 0);
        push_payload(n_payload);
    endtask

    // Track what a well-formed packet does to the generator's view
    task automatic note_packet(input int n_payload);
        gen_left = gen_left - ((n_payload < gen_left) ? n_payload : gen_left);
        if (gen_left != 0)
            gen_seq = gen_seq + 8'd1;
    endtask

    // Compare one field of a progress report
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // Drive requests at the falling edge and vary the receiver's readiness
    always @(negedge clk)
    begin
        link_req_t nxt;
        int        stage;
        int        tx_idle_pct;
        int        rx_idle_pct;
        stage = (total_reqs == 0) ? 0 : (reqs_taken * 3) / total_reqs;
        tx_idle_pct = (stage == 0) ? 34 : (stage == 1) ? 50 : 0;
        rx_idle_pct = (stage == 0) ? 50 : (stage == 1) ? 34 : 0;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (link_reqs_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                nxt = link_reqs_pending.pop_front();
                s_axis_tuser  <= nxt.kind;
                s_axis_tdata  <= nxt.octet;
                s_axis_tlast  <= nxt.eop;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        progress_t    want;
        report_bits_t seen;
        if (s_axis_tvalid && s_axis_tready)
        begin
            progress_due.push_back(advance_reassembly(s_axis_tuser, s_axis_tdata, s_axis_tlast));
            reqs_taken++;
        end
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready)
        begin
            seen = report_bits_t'(m_axis_tdata);
            reports_seen++;
            if (progress_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, actual tdata 0x%0h tuser %0b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = progress_due.pop_front();
                check_field("status", want.status, seen.status);
                check_field("expected_seq", want.seq, seen.seq);
                check_field("payload_valid", want.valid, m_axis_tuser[0]);
                check_field("payload_out", want.data, seen.data);
                check_field("payload_offset", want.offset, seen.offset);
                check_field("transfer_length", want.length, seen.length);
                check_field("error_cause", want.cause, seen.cause);
                if (want.valid)
                    payload_seen++;
                if (want.status == spr_pkg::ST_SUCCESS)
                    success_seen++;
                if (want.status == spr_pkg::ST_ERROR)
                    error_seen++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Abort when neither side has moved for too long
    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result accepted for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int         n;
        int         budget;
        bit         wrap_done;
        logic [15:0] len;
        wrap_done = 1'b0;

        // Directed: start, payload extremes, completion and every error cause
        push_req(spr_pkg::REQ_CLEAR, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h05, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'hFF, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b1);
        push_req(spr_pkg::REQ_BYTE, 8'h01, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'hAA, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h55, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h12, 1'b1);
        // matching packet after the transfer has finished
        push_req(spr_pkg::REQ_BYTE, 8'h01, 1'b1);
        // unexpected start, then a wrong sequence with a discarded tail
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b1);
        push_req(spr_pkg::REQ_BYTE, 8'h07, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h03, 1'b1);
        push_req(spr_pkg::REQ_CLEAR, 8'hFF, 1'b1);
        // short starts ending at the sequence byte and at the low length byte
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b1);
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h09, 1'b1);
        // maximum length committed by a packet ending at the high length byte
        push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'hFF, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'hFF, 1'b1);
        // empty notice in the middle of a packet, then an unused request
        push_req(spr_pkg::REQ_BYTE, 8'h01, 1'b0);
        push_req(spr_pkg::REQ_BYTE, 8'h80, 1'b0);
        push_req(spr_pkg::REQ_EMPTY, 8'h5A, 1'b0);
        push_req(REQ_UNUSED, 8'hFF, 1'b1);
        // continuation while in error keeps the error status
        push_req(spr_pkg::REQ_BYTE, 8'h01, 1'b1);
        gen_seq = 8'h02;

        // Random: mostly well-formed transfers, with noise and broken packets mixed in
        n = stim_items + RANDOM_REQS;
        while (stim_items < n)
        begin
            if (gen_seq != 8'h00)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_start(16'($urandom), $urandom_range(0, 3));
                push_req(spr_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom));
                gen_seq = 8'h00;
            end
            if (!wrap_done && stim_items > 300)
            begin
                // Run the expected sequence all the way round
                push_start(16'd3, 0);
                for (int s = 1; s < 256; s++)
                    push_packet(8'(s), 0);
                gen_seq   = 8'h00;
                wrap_done = 1'b1;
                continue;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b1);
                else
                begin
                    push_req(spr_pkg::REQ_BYTE, 8'h00, 1'b0);
                    push_req(spr_pkg::REQ_BYTE, 8'($urandom), 1'b1);
                end
            end
            case ($urandom_range(0, 19))
                0:       len = 16'h0000;
                1:       len = 16'($urandom);
                2:       len = 16'hFFFF;
                default: len = 16'($urandom_range(1, 30));
            endcase
            budget   = (len > 16'd64) ? 4 : 64;
            gen_left = len;
            n_start:
            begin
                int k;
                k = $urandom_range(0, 6);
                push_start(len, k);
                gen_seq = 8'h00;
                note_packet(k);
            end
            while (gen_left != 0 && budget != 0)
            begin
                int k;
                budget--;
                case ($urandom_range(0, 19))
                    0: push_packet(gen_seq + 8'($urandom_range(1, 255)), $urandom_range(0, 4));
                    1: push_start(16'($urandom), 2);
                    2:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            push_req(spr_pkg::REQ_BYTE, gen_seq, 1'b0);
                        push_req(spr_pkg::REQ_EMPTY, 8'($urandom), 1'($urandom));
                    end
                    3: push_req(REQ_UNUSED, 8'($urandom), 1'($urandom));
                    default:
                    begin
                        k = $urandom_range(0, 6);
                        push_packet(gen_seq, k);
                        note_packet(k);
                    end
                endcase
            end
            // Abandon an over-long transfer, or poke a finished one
            if (gen_left != 0)
            begin
                push_req(spr_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom));
                gen_seq = 8'h00;
            end
            else if ($urandom_range(0, 3) == 0)
                push_packet(gen_seq, $urandom_range(0, 3));
        end
        total_reqs = link_reqs_pending.size();

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (reqs_taken != total_reqs)
            @(posedge clk);
        while (progress_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (progress_due.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, progress_due.size());
        end
        $display("Sent %0d requests and checked %0d results across idle and stall phases.",
                 total_reqs, reports_seen);
        $display("Saw %0d payload bytes, %0d success reports and %0d error reports.",
                 payload_seen, success_seen, error_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
